// ===== rtl/ssds_pkg.sv =====
// ----------------------------------------------------------------------------
// ssds_pkg
// shared types and constants of the stepped servo duty sequencer
// ----------------------------------------------------------------------------
package ssds_pkg;

   localparam int NUM_SERVOS = 4;
   localparam int SERVO_W    = 2;
   localparam int ANGLE_W    = 8;
   localparam int PULSE_W    = 15;
   localparam int DUTY_W     = 13;
   localparam int THR_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;
   localparam int STEP_CNT_W = 5;

   localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
   localparam logic [ANGLE_W-1:0] ANGLE_RESET = 8'd90;
   localparam logic [ANGLE_W-1:0] STEP_DEG    = 8'd10;

   // divide by ten for values up to 180: (x * 205) >> 11
   localparam logic [ANGLE_W-1:0] STEP_RECIP = 8'd205;
   localparam int                 STEP_SHIFT = 11;

   localparam logic [PULSE_W-1:0] MIN_PULSE_RESET = 15'd500;
   localparam logic [PULSE_W-1:0] MAX_PULSE_RESET = 15'd2500;
   localparam logic [THR_W-1:0]   THR_RESET       = 8'd20;
   localparam logic [NUM_SERVOS-1:0] MIRROR_RESET = 4'd10;

   // angle * span, and its reciprocal product for the divide by 180
   localparam int PROD_W      = PULSE_W + ANGLE_W;
   localparam int ANGLE_SHIFT = 31;
   localparam logic [31:0] RECIP_ANGLE = 32'((64'd1 << ANGLE_SHIFT) / 64'd180);
   localparam int DIV1_W      = PROD_W + 32;

   localparam logic [31:0] PERIOD_US    = 32'd20000;
   localparam logic [31:0] DUTY_LEVELS  = 32'd8192;
   localparam int          PERIOD_SHIFT = 32;
   localparam logic [31:0] RECIP_PERIOD = 32'((64'd1 << PERIOD_SHIFT) / 64'(PERIOD_US));
   localparam logic [31:0] DUTY_MAX     = 32'd8191;

   localparam int PIPE_DEPTH = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_PULSE = 2'd0,
      CSR_MAX_PULSE = 2'd1,
      CSR_STEP_THR  = 2'd2,
      CSR_MIRROR    = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic load;
      logic issue_step;
      logic issue_final;
   } cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic pipe_busy;
   } status_type;

endpackage

// ===== rtl/ssds_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssds_ctrl
// sequencer: loads a command, issues intermediate and final angles, drains
// ----------------------------------------------------------------------------
module ssds_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output ssds_pkg::cmd_type    cmd,
   input  ssds_pkg::status_type status
);

   ssds_pkg::state_type state_ff;
   ssds_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ssds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ssds_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ssds_pkg::ST_STEP;
            end
         end
         ssds_pkg::ST_STEP: begin
            if (status.steps_zero) begin
               cmd.issue_final = 1'b1;
               state_in        = ssds_pkg::ST_DRAIN;
            end else begin
               cmd.issue_step = 1'b1;
            end
         end
         ssds_pkg::ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = ssds_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ssds_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ssds_pkg::ST_IDLE);

endmodule

// ===== rtl/ssds_datapath.sv =====
// ----------------------------------------------------------------------------
// ssds_datapath
// control registers, angle store, step arithmetic and duty pipeline
// ----------------------------------------------------------------------------
module ssds_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ssds_pkg::cmd_type                 cmd,
   output ssds_pkg::status_type              status,
   input  logic [ssds_pkg::SERVO_W-1:0]      req_servo_sel,
   input  logic [ssds_pkg::ANGLE_W-1:0]      req_target_angle,
   input  logic                              csr_write,
   input  logic [ssds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssds_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   output logic [ssds_pkg::SERVO_W-1:0]      rsp_out_servo,
   output logic [ssds_pkg::DUTY_W-1:0]       rsp_duty_value,
   output logic                              rsp_last_update
);

   localparam int AW = ssds_pkg::ANGLE_W;
   localparam int PW = ssds_pkg::PULSE_W;
   localparam int RW = ssds_pkg::PROD_W;
   localparam int NS = ssds_pkg::NUM_SERVOS;
   localparam int PD = ssds_pkg::PIPE_DEPTH;

   // control registers
   logic [PW-1:0]             min_pulse_ff;
   logic [PW-1:0]             max_pulse_ff;
   logic [ssds_pkg::THR_W-1:0] step_thr_ff;
   logic [NS-1:0]             mirror_ff;

   // angle store and move state
   logic [AW-1:0]                     angle_ff [NS];
   logic [ssds_pkg::SERVO_W-1:0]      sel_ff;
   logic [AW-1:0]                     target_ff;
   logic [AW-1:0]                     cur_ff;
   logic                              up_ff;
   logic                              mirrored_ff;
   logic [ssds_pkg::STEP_CNT_W-1:0]   steps_ff;

   // pipeline
   logic [PD-1:0]                valid_ff;
   logic [PD-1:0]                last_ff;
   logic [RW-1:0]                prod_ff;
   logic [RW-1:0]                prod2_ff;
   logic [ssds_pkg::DIV1_W-1:0]  div1_ff;
   logic [15:0]                  pulse_ff;
   logic [31:0]                  num_ff;
   logic [31:0]                  num2_ff;
   logic [63:0]                  div2_ff;
   logic [ssds_pkg::DUTY_W-1:0]  duty_ff;

   // load path
   logic [AW-1:0]                   tgt_clamp;
   logic [AW-1:0]                   cur_rd;
   logic [AW-1:0]                   cur_clamp;
   logic                            up_load;
   logic [AW-1:0]                   diff;
   logic [2*AW-1:0]                 quot_prod;
   logic [ssds_pkg::STEP_CNT_W-1:0] steps_load;

   // issue path
   logic [AW-1:0] cur_step;
   logic [AW-1:0] issue_angle;
   logic [AW-1:0] drive;
   logic [PW-1:0] span;
   logic          issue;

   // divide corrections
   logic [PW-1:0] q1;
   logic [RW-1:0] rem1;
   logic [31:0]   q2;
   logic [31:0]   rem2;
   logic [31:0]   q2_fix;
   logic [ssds_pkg::DUTY_W-1:0] duty_in;

   always_comb begin
      tgt_clamp  = (req_target_angle > ssds_pkg::ANGLE_MAX) ? ssds_pkg::ANGLE_MAX
                                                            : req_target_angle;
      cur_rd     = angle_ff[req_servo_sel];
      cur_clamp  = (cur_rd > ssds_pkg::ANGLE_MAX) ? ssds_pkg::ANGLE_MAX : cur_rd;
      up_load    = (tgt_clamp > cur_clamp);
      diff       = up_load ? (tgt_clamp - cur_clamp) : (cur_clamp - tgt_clamp);
      quot_prod  = (2*AW)'(diff) * (2*AW)'(ssds_pkg::STEP_RECIP);
      steps_load = (diff > step_thr_ff)
                 ? ssds_pkg::STEP_CNT_W'(quot_prod >> ssds_pkg::STEP_SHIFT) : '0;
   end

   always_comb begin
      cur_step    = up_ff ? (cur_ff + ssds_pkg::STEP_DEG) : (cur_ff - ssds_pkg::STEP_DEG);
      issue_angle = cmd.issue_final ? target_ff : cur_step;
      drive       = mirrored_ff ? (ssds_pkg::ANGLE_MAX - issue_angle) : issue_angle;
      span        = (max_pulse_ff >= min_pulse_ff) ? (max_pulse_ff - min_pulse_ff) : '0;
      issue       = cmd.issue_step | cmd.issue_final;
   end

   always_comb begin
      q1     = PW'(div1_ff >> ssds_pkg::ANGLE_SHIFT);
      rem1   = prod2_ff - RW'(RW'(q1) * RW'(ssds_pkg::ANGLE_MAX));
      q2     = 32'(div2_ff >> ssds_pkg::PERIOD_SHIFT);
      rem2   = num2_ff - 32'(q2 * ssds_pkg::PERIOD_US);
      q2_fix = q2 + 32'(rem2 >= ssds_pkg::PERIOD_US);
      duty_in = (q2_fix > ssds_pkg::DUTY_MAX) ? ssds_pkg::DUTY_W'(ssds_pkg::DUTY_MAX)
                                              : ssds_pkg::DUTY_W'(q2_fix);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_pulse_ff <= ssds_pkg::MIN_PULSE_RESET;
         max_pulse_ff <= ssds_pkg::MAX_PULSE_RESET;
         step_thr_ff  <= ssds_pkg::THR_RESET;
         mirror_ff    <= ssds_pkg::MIRROR_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ssds_pkg::CSR_MIN_PULSE: min_pulse_ff <= PW'(csr_wdata);
            ssds_pkg::CSR_MAX_PULSE: max_pulse_ff <= PW'(csr_wdata);
            ssds_pkg::CSR_STEP_THR:  step_thr_ff  <= ssds_pkg::THR_W'(csr_wdata);
            ssds_pkg::CSR_MIRROR:    mirror_ff    <= NS'(csr_wdata);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            angle_ff[i] <= ssds_pkg::ANGLE_RESET;
         end
      end else if (cmd.issue_final) begin
         angle_ff[sel_ff] <= target_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else if (cmd.load) begin
         steps_ff <= steps_load;
      end else if (cmd.issue_step) begin
         steps_ff <= steps_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sel_ff      <= req_servo_sel;
         target_ff   <= tgt_clamp;
         cur_ff      <= cur_clamp;
         up_ff       <= up_load;
         mirrored_ff <= mirror_ff[req_servo_sel];
      end else if (cmd.issue_step) begin
         cur_ff <= cur_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[PD-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= {last_ff[PD-2:0], cmd.issue_final};
      prod_ff  <= RW'(drive) * RW'(span);
      div1_ff  <= ssds_pkg::DIV1_W'(prod_ff) * ssds_pkg::DIV1_W'(ssds_pkg::RECIP_ANGLE);
      prod2_ff <= prod_ff;
      pulse_ff <= 16'(min_pulse_ff) + 16'(q1) + 16'(rem1 >= RW'(ssds_pkg::ANGLE_MAX));
      num_ff   <= 32'(pulse_ff) * ssds_pkg::DUTY_LEVELS;
      div2_ff  <= 64'(num_ff) * 64'(ssds_pkg::RECIP_PERIOD);
      num2_ff  <= num_ff;
      duty_ff  <= duty_in;
   end

   assign status.steps_zero = (steps_ff == '0);
   assign status.pipe_busy  = |valid_ff;

   assign rsp_valid       = valid_ff[PD-1];
   assign rsp_last_update = last_ff[PD-1];
   assign rsp_duty_value  = duty_ff;
   assign rsp_out_servo   = sel_ff;

endmodule

// ===== rtl/stepped_servo_duty_sequencer.sv =====
// ----------------------------------------------------------------------------
// stepped_servo_duty_sequencer
// servo angle commands to stepped 13-bit pwm duty updates
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. A move of n updates
// (n is 1, or diff/10 + 1 when the change exceeds the step threshold, at most
// 19) issues one angle per cycle into a six-stage duty pipeline (multiply by
// span, divide by 180, offset, scale by levels, divide by period, saturate),
// so updates leave one per cycle, and busy stays high until the last update
// has left the pipeline. Every update is on the rsp_ ports for one cycle
// with rsp_valid; the receiver cannot stall. The csr port is always ready;
// the user must see it is written only while busy is low; it is not enforced.
// ----------------------------------------------------------------------------
module stepped_servo_duty_sequencer (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ssds_pkg::SERVO_W-1:0]    req_servo_sel,
   input  logic [ssds_pkg::ANGLE_W-1:0]    req_target_angle,
   output logic                            rsp_valid,
   output logic [ssds_pkg::SERVO_W-1:0]    rsp_out_servo,
   output logic [ssds_pkg::DUTY_W-1:0]     rsp_duty_value,
   output logic                            rsp_last_update,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ssds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ssds_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ssds_pkg::cmd_type    cmd;
   ssds_pkg::status_type status;

   assign csr_ready = 1'b1;

   ssds_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   ssds_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_servo_sel    (req_servo_sel),
      .req_target_angle (req_target_angle),
      .csr_write        (csr_valid & csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_out_servo    (rsp_out_servo),
      .rsp_duty_value   (rsp_duty_value),
      .rsp_last_update  (rsp_last_update)
   );

   // results only while a transaction is in flight
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a transaction");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // nothing follows the final update of a move
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_update) |=> !rsp_valid)
      else $error("result after final update");

endmodule
